// ----- design/dlpd_pkg.sv -----
`default_nettype none

package dlpd_pkg;

    localparam int CAPACITY    = 1024;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int COUNT_W     = 11;
    localparam int VALUE_W     = 32;
    localparam int MAG_W       = VALUE_W + 4;
    localparam int MAX_RESULTS = 2;
    localparam int RESQ_DEPTH  = 4;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(32'h7FFF_FFFF);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(32'h8000_0000);

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SYNTAX = 3'd1,
        ST_RANGE  = 3'd2,
        ST_DUP    = 3'd3,
        ST_EMPTY  = 3'd4,
        ST_FULL   = 3'd5,
        ST_DONE   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_SEARCH,
        S_FINISH
    } state_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]         count;
        logic                       run_end;
    } result_t;

endpackage

`default_nettype wire

// ----- design/dlpd_channels.sv -----
`default_nettype none

interface dlpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_req;

    modport source (output valid, output ch, output final_req, input ready);
    modport sink   (input valid, input ch, input final_req, output ready);
endinterface

interface dlpd_res_if;
    logic                                 valid;
    logic                                 ready;
    dlpd_pkg::status_t                    status;
    logic signed [dlpd_pkg::VALUE_W-1:0]  value;
    logic [dlpd_pkg::COUNT_W-1:0]         count;
    logic                                 run_end;

    modport source (output valid, output status, output value, output count,
                    output run_end, input ready);
    modport sink   (input valid, input status, input value, input count,
                    input run_end, output ready);
endinterface

`default_nettype wire

// ----- design/dlpd_store.sv -----
`default_nettype none

module dlpd_store (
    input  wire logic                          clk,
    input  wire logic                          rd_en,
    input  wire logic [dlpd_pkg::ADDR_W-1:0]   rd_addr,
    output logic      [dlpd_pkg::VALUE_W-1:0]  rd_data,
    input  wire logic                          wr_en,
    input  wire logic [dlpd_pkg::ADDR_W-1:0]   wr_addr,
    input  wire logic [dlpd_pkg::VALUE_W-1:0]  wr_data
);
    import dlpd_pkg::*;

    logic [VALUE_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/dlpd_resq.sv -----
`default_nettype none

module dlpd_resq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dlpd_pkg::result_t  push_data,
    output logic                    room,
    dlpd_res_if.source              res
);
    import dlpd_pkg::*;

    result_t                 slot_reg [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RESQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RESQ_CNT_W-1:0]   fill_reg, fill_next;
    logic                    pop;
    result_t                 head;

    assign pop  = res.valid && res.ready;
    assign head = slot_reg[rd_ptr_reg];

    assign res.valid   = (fill_reg != '0);
    assign res.status  = head.status;
    assign res.value   = head.value;
    assign res.count   = head.count;
    assign res.run_end = head.run_end;

    // leave space for every result one request can raise
    assign room = (fill_reg <= RESQ_CNT_W'(RESQ_DEPTH - MAX_RESULTS));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + RESQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + RESQ_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + RESQ_CNT_W'(push) - RESQ_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/decimal_list_parser_dedup.sv -----
// Decimal list parser with duplicate rejection. Takes one argument byte per
// request (0 ends an argument, final_req marks the last byte) and returns, in
// order, each accepted int32 value, the first error (syntax, range, duplicate,
// empty argument, store full) or a done result with the count; after an error
// or done, further requests are taken and dropped until reset. A byte that
// ends a number starts a duplicate search, which reads the value store one
// entry per cycle through one shared comparator before the value is appended.
// A final byte that is not 0 is handled as if a terminating 0 followed it.
// Results leave through a 4-entry queue, so requests keep flowing while results
// wait to be taken, as long as the queue has room for the results of a request.
`default_nettype none

module decimal_list_parser_dedup (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dlpd_byte_if.sink   arg,
    dlpd_res_if.source  res
);
    import dlpd_pkg::*;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic                 seen_reg, seen_next;
    logic                 failed_reg, failed_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 fin_reg, fin_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 rd_vld_reg, rd_vld_next;

    logic                 is_digit, is_sign, is_space, is_zero;
    logic [VALUE_W-1:0]   mag_base;
    logic                 neg_eff;
    logic [MAG_W-1:0]     acc;
    logic [MAG_W-1:0]     limit;
    logic                 overflow;

    logic                 room;
    logic                 push;
    result_t              push_data;

    logic                 rd_en;
    logic [VALUE_W-1:0]   rd_data;
    logic                 wr_en;
    logic                 issue;
    logic                 match;

    assign is_digit = (byte_reg inside {[CH_ZERO:CH_NINE]});
    assign is_sign  = (byte_reg == CH_PLUS) || (byte_reg == CH_MINUS);
    assign is_space = (byte_reg inside {[CH_TAB:CH_CR], CH_SPACE});
    assign is_zero  = (byte_reg == CH_NUL);

    // a digit at the start of a number begins from zero magnitude, positive
    assign mag_base = (phase_reg == PH_SKIP) ? '0 : mag_reg;
    assign neg_eff  = (phase_reg == PH_SKIP) ? 1'b0 : neg_reg;
    assign acc      = ({4'd0, mag_base} << 3) + ({4'd0, mag_base} << 1)
                      + MAG_W'(4'(byte_reg - CH_ZERO));
    assign limit    = neg_eff ? NEG_LIMIT : POS_LIMIT;
    assign overflow = (acc > limit);

    assign issue = (idx_reg < cnt_reg);
    assign match = rd_vld_reg && (rd_data == val_reg);
    assign rd_en = (state_reg == S_SEARCH) && issue && !match;
    assign wr_en = (state_reg == S_FINISH) && (cnt_reg < CNT_W'(CAPACITY));

    assign arg.ready = (state_reg == S_IDLE) && room;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        seen_next   = seen_reg;
        failed_next = failed_reg;
        cnt_next    = cnt_reg;
        byte_next   = byte_reg;
        fin_next    = fin_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        rd_vld_next = 1'b0;

        push              = 1'b0;
        push_data.status  = ST_OK;
        push_data.value   = '0;
        push_data.count   = COUNT_W'(cnt_reg);
        push_data.run_end = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (arg.valid && arg.ready && !failed_reg)
                begin
                    byte_next  = arg.ch;
                    fin_next   = arg.final_req;
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                logic    err;
                status_t err_code;
                logic    commit_go;
                logic    add_digit;

                err       = 1'b0;
                err_code  = ST_SYNTAX;
                commit_go = 1'b0;
                add_digit = 1'b0;

                case (phase_reg)
                    PH_SIGNED:
                    begin
                        if (is_digit)
                            add_digit = 1'b1;
                        else
                            err = 1'b1;
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                            add_digit = 1'b1;
                        else if (is_sign)
                            err = 1'b1;
                        else
                            commit_go = 1'b1;
                    end
                    default:
                    begin
                        if (is_zero)
                        begin
                            if (!seen_reg)
                            begin
                                err      = 1'b1;
                                err_code = ST_EMPTY;
                            end
                            seen_next = 1'b0;
                        end
                        else if (is_sign)
                        begin
                            neg_next   = (byte_reg == CH_MINUS);
                            mag_next   = '0;
                            phase_next = PH_SIGNED;
                        end
                        else if (is_digit)
                        begin
                            add_digit = 1'b1;
                        end
                        else if (!is_space)
                        begin
                            err = 1'b1;
                        end
                    end
                endcase

                if (add_digit)
                begin
                    seen_next  = 1'b1;
                    phase_next = PH_DIGITS;
                    neg_next   = neg_eff;
                    if (overflow)
                    begin
                        err      = 1'b1;
                        err_code = ST_RANGE;
                    end
                    else
                    begin
                        mag_next = acc[VALUE_W-1:0];
                    end
                end

                if (err)
                begin
                    push             = 1'b1;
                    push_data.status = err_code;
                    failed_next      = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (commit_go)
                begin
                    val_next   = neg_reg ? (VALUE_W'(0) - mag_reg) : mag_reg;
                    idx_next   = '0;
                    state_next = S_SEARCH;
                end
                else if (fin_reg)
                begin
                    if (is_zero)
                    begin
                        push             = 1'b1;
                        push_data.status = ST_DONE;
                        failed_next      = 1'b1;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        // finish as if a terminating zero followed
                        byte_next = CH_NUL;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_SEARCH:
            begin
                if (match)
                begin
                    push             = 1'b1;
                    push_data.status = ST_DUP;
                    failed_next      = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    if (issue)
                        idx_next = idx_reg + CNT_W'(1);
                    rd_vld_next = issue;
                    if (!issue && !rd_vld_reg)
                        state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!wr_en)
                begin
                    push             = 1'b1;
                    push_data.status = ST_FULL;
                    failed_next      = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    cnt_next          = cnt_reg + CNT_W'(1);
                    push              = 1'b1;
                    push_data.status  = ST_OK;
                    push_data.value   = val_reg;
                    push_data.count   = COUNT_W'(cnt_reg + CNT_W'(1));
                    // more follows on a final byte or a stray trailing byte
                    push_data.run_end = !(fin_reg || (!is_zero && !is_space));
                    phase_next        = PH_SKIP;
                    // replay the ending byte from the skip phase
                    state_next        = S_STEP;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_SKIP;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            seen_reg   <= 1'b0;
            failed_reg <= 1'b0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            mag_reg    <= mag_next;
            seen_reg   <= seen_next;
            failed_reg <= failed_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        fin_reg  <= fin_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
    end

    dlpd_store u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (val_reg)
    );

    dlpd_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .room      (room),
        .res       (res)
    );

endmodule

`default_nettype wire

// ----- design/dlpd_checker.sv -----
`default_nettype none

module dlpd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [2:0]                    res_status,
    input wire logic [dlpd_pkg::VALUE_W-1:0]  res_value,
    input wire logic [dlpd_pkg::COUNT_W-1:0]  res_count,
    input wire logic                          res_run_end
);
    import dlpd_pkg::*;

    logic stop_reg;

    // any error or done closes the result stream until reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg <= 1'b0;
        end
        else if (res_valid && res_ready && (res_status != ST_OK))
        begin
            stop_reg <= 1'b1;
        end
    end

    a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_status == ST_OK) || (res_value == '0))
        else $error("nonzero value on a result that is not an accept");

    a_error_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != ST_OK) |-> res_run_end)
        else $error("error or done result not marked as last of its request");

    a_silent_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> !res_valid)
        else $error("result after an error or done");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status)
            && $stable(res_value) && $stable(res_count) && $stable(res_run_end))
        else $error("stalled result changed");

endmodule

bind decimal_list_parser_dedup dlpd_checker u_dlpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_status  (res.status),
    .res_value   (res.value),
    .res_count   (res.count),
    .res_run_end (res.run_end)
);

`default_nettype wire
